// File: rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg: shared types and codes of the tone melody sequencer
// Command codes, decoded item kinds, the queued item layout and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tms_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 6;
  localparam int FREQ_W = 16;
  localparam int DUR_W  = 16;
  localparam int LEN_W  = 7;
  localparam int REP_W  = 8;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Command codes as they arrive on the input tuser.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PLAY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

  // Kinds of item after classification by the front end.
  localparam logic [2:0] KIND_NOP   = 3'd0;
  localparam logic [2:0] KIND_TICK  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_PLAY  = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]        kind;
    logic [IDX_W-1:0]  index;
    logic [FREQ_W-1:0] frequency;
    logic [DUR_W-1:0]  duration;
    logic [LEN_W-1:0]  length;
    logic [REP_W-1:0]  repeats;
  } tms_item_t;

endpackage

`default_nettype wire

// File: rtl/tms_front.sv
// ----------------------------------------------------------------------------
// tms_front: input classification
// Unpacks an input item, saturates the melody length, maps a repeat count of
// zero to one and turns out-of-table writes into no-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_front #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [tms_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [tms_pkg::CMD_W-1:0]     s_tuser,
  input  wire logic                          queue_full,
  output logic                               push,
  output tms_pkg::tms_item_t                 item
);

  localparam logic [7:0] DEPTH_L = 8'(TABLE_DEPTH);

  logic [tms_pkg::IDX_W-1:0]  index;
  logic [tms_pkg::FREQ_W-1:0] frequency;
  logic [tms_pkg::DUR_W-1:0]  duration;
  logic [tms_pkg::LEN_W-1:0]  length;
  logic [tms_pkg::REP_W-1:0]  repeats;

  assign index     = s_tdata[5:0];
  assign frequency = s_tdata[21:6];
  assign duration  = s_tdata[37:22];
  assign length    = s_tdata[44:38];
  assign repeats   = s_tdata[52:45];

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    item.index     = index;
    item.frequency = frequency;
    item.duration  = duration;
    item.length    = ({1'b0, length} > DEPTH_L) ? DEPTH_L[6:0] : length;
    item.repeats   = (repeats == '0) ? 8'd1 : repeats;
    unique case (s_tuser)
      tms_pkg::CMD_TICK:  item.kind = tms_pkg::KIND_TICK;
      tms_pkg::CMD_WRITE: begin
        item.kind = ({2'b00, index} < DEPTH_L) ? tms_pkg::KIND_WRITE : tms_pkg::KIND_NOP;
      end
      tms_pkg::CMD_PLAY:  item.kind = tms_pkg::KIND_PLAY;
      default:            item.kind = tms_pkg::KIND_STOP;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tms_queue.sv
// ----------------------------------------------------------------------------
// tms_queue: two-entry item queue
// Decouples classification from execution; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tms_pkg::tms_item_t din,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  output tms_pkg::tms_item_t      dout
);

  tms_pkg::tms_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/tms_back.sv
// ----------------------------------------------------------------------------
// tms_back: melody execution
// Holds the note table and the playback state, carries out one queued item a
// cycle while the output is not stalled and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire tms_pkg::tms_item_t             item,
  output logic                                pop,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [tms_pkg::OUT_DATA_W-1:0]      m_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = tms_pkg::LEN_W;

  // Note table: frequency in the upper half, duration in the lower half.
  logic [31:0]   note_mem [TABLE_DEPTH];
  logic [15:0]   rd_freq;
  logic [15:0]   rd_dur;
  logic [15:0]   entry0_freq;
  logic [15:0]   entry0_dur;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  logic [NW-1:0] next_note,         next_note_next;
  logic [NW-1:0] active_length,     active_length_next;
  logic [15:0]   elapsed_ms,        elapsed_ms_next;
  logic [15:0]   current_duration,  current_duration_next;
  logic [15:0]   current_frequency, current_frequency_next;
  logic [7:0]    plays_left,        plays_left_next;
  logic          busy,              busy_next;

  logic          take;
  logic          do_advance;
  logic [15:0]   elapsed_inc;
  logic          at_end;
  logic          sounding;
  logic [AW+tms_pkg::IDX_W-1:0] wr_wide;
  logic [AW+NW-1:0]             rd_wide;

  assign take = in_valid && (!m_tvalid || m_tready);
  assign pop  = take;

  assign wr_wide = {{AW{1'b0}}, item.index};
  assign wr_addr = wr_wide[AW-1:0];

  assign elapsed_inc = (elapsed_ms != tms_pkg::ELAPSED_MAX) ? elapsed_ms + 16'd1 : elapsed_ms;
  assign at_end      = (next_note >= active_length);

  always_comb begin
    next_note_next         = next_note;
    active_length_next     = active_length;
    elapsed_ms_next        = elapsed_ms;
    current_duration_next  = current_duration;
    current_frequency_next = current_frequency;
    plays_left_next        = plays_left;
    busy_next              = busy;
    wr_en                  = 1'b0;
    do_advance             = 1'b0;

    if (take) begin
      case (item.kind)
        tms_pkg::KIND_TICK: begin
          if (busy) begin
            elapsed_ms_next = elapsed_inc;
            do_advance      = (elapsed_inc >= current_duration);
          end
        end
        tms_pkg::KIND_WRITE: wr_en = 1'b1;
        tms_pkg::KIND_PLAY: begin
          active_length_next = item.length;
          next_note_next     = '0;
          if (item.length == '0) begin
            busy_next              = 1'b0;
            current_frequency_next = '0;
            plays_left_next        = '0;
          end else begin
            busy_next              = 1'b1;
            plays_left_next        = item.repeats;
            current_frequency_next = entry0_freq;
            current_duration_next  = entry0_dur;
            elapsed_ms_next        = '0;
            next_note_next         = 7'd1;
          end
        end
        tms_pkg::KIND_STOP: begin
          busy_next              = 1'b0;
          current_frequency_next = '0;
          plays_left_next        = '0;
        end
        default: ;
      endcase
    end

    // Step to the next note; the prefetched entry is the one it needs.
    if (do_advance) begin
      if (active_length == '0 || (at_end && plays_left <= 8'd1)) begin
        busy_next              = 1'b0;
        current_frequency_next = '0;
        plays_left_next        = '0;
      end else begin
        current_frequency_next = rd_freq;
        current_duration_next  = rd_dur;
        elapsed_ms_next        = '0;
        if (at_end) begin
          plays_left_next = plays_left - 8'd1;
          next_note_next  = 7'd1;
        end else begin
          next_note_next  = next_note + 7'd1;
        end
      end
    end
  end

  // Prefetch the entry that the next advance would load.
  assign rd_wide = {{AW{1'b0}}, next_note_next};
  assign rd_addr = (next_note_next >= active_length_next) ? '0 : rd_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      note_mem[wr_addr] <= {item.frequency, item.duration};
    end
    if (wr_en && wr_addr == rd_addr) begin
      {rd_freq, rd_dur} <= {item.frequency, item.duration};
    end else begin
      {rd_freq, rd_dur} <= note_mem[rd_addr];
    end
    if (wr_en && item.index == '0) begin
      entry0_freq <= item.frequency;
      entry0_dur  <= item.duration;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_note         <= '0;
      active_length     <= '0;
      elapsed_ms        <= '0;
      current_duration  <= '0;
      current_frequency <= '0;
      plays_left        <= '0;
      busy              <= 1'b0;
    end else begin
      next_note         <= next_note_next;
      active_length     <= active_length_next;
      elapsed_ms        <= elapsed_ms_next;
      current_duration  <= current_duration_next;
      current_frequency <= current_frequency_next;
      plays_left        <= plays_left_next;
      busy              <= busy_next;
    end
  end

  assign sounding = busy_next && (current_frequency_next != '0);

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {7'd0, next_note_next, busy_next,
                  (sounding ? current_frequency_next : 16'd0), sounding};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_busy_has_position: assert property (@(posedge clk) disable iff (rst)
    busy |-> (next_note != '0 && next_note <= active_length))
    else $error("playing with a note position outside the melody");

  a_busy_has_plays: assert property (@(posedge clk) disable iff (rst)
    busy |-> plays_left != '0)
    else $error("playing with no plays left");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    !busy |-> current_frequency == '0)
    else $error("idle with a frequency held");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(next_note) && $stable(busy) && $stable(elapsed_ms))
    else $error("playback state moved without an item");

endmodule

`default_nettype wire

// File: rtl/tone_melody_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tone_melody_sequencer_unit: note table melody player
// Loads a table of notes, plays it on millisecond ticks with repeats, and
// reports the sounding tone after every item.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Fields (lowest bit first)
// -------  ---------  ---------------------------------------------------------
// s_*      in         tuser: cmd; tdata: entry_index, entry_frequency,
//                     entry_duration_ms, melody_length, repeat_count
// m_*      out        tdata: tone_active, tone_frequency, melody_busy,
//                     note_position
//
// One result item leaves for every input item, in order. The block takes one
// item per clock cycle while the output is not stalled; each item passes
// through the two-entry queue and then the output register before its result
// leaves. The rate is set by the playback state update, which finishes each
// item using a note table entry that is registered ahead of the step that
// needs it. Reset is synchronous and leaves the player idle; the note table
// holds no value until written. A stalled output holds the queue, and the
// input is refused only once both queue entries are full.
//
`default_nettype none

module tone_melody_sequencer_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // entry_index[5:0], entry_frequency[21:6], entry_duration_ms[37:22],
  // melody_length[44:38], repeat_count[52:45], zero fill [55:53]
  input  wire logic [tms_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  wire logic [tms_pkg::CMD_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // tone_active[0], tone_frequency[16:1], melody_busy[17],
  // note_position[24:18], zero fill [31:25]
  output logic [tms_pkg::OUT_DATA_W-1:0]      m_tdata
);

  tms_pkg::tms_item_t front_item;
  tms_pkg::tms_item_t head_item;
  logic               push;
  logic               pop;
  logic               queue_full;
  logic               queue_empty;

  // Front end: unpack and classify each accepted item.
  tms_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item)
  );

  // Short queue so that either side may stall on its own.
  tms_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (queue_full),
    .empty (queue_empty),
    .pop   (pop),
    .dout  (head_item)
  );

  // Back end: note table, playback state and the result register.
  tms_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!queue_empty),
    .item     (head_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
